// ===== rtl/core/nbrtab_pkg.sv =====
// ----------------------------------------------------------------------------
// nbrtab_pkg
// shared types, codes and constants of the age-ordered neighbor table
// ----------------------------------------------------------------------------
package nbrtab_pkg;

    // default table depth
    localparam int TABLE_DEPTH_DEF = 16;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_MIN_DISTANCE = 1'b0;
    localparam logic REG_MAX_AGE      = 1'b1;
    localparam logic [31:0] MAX_AGE_RESET = 32'd1000;

    // request modes
    localparam logic [1:0] MODE_MSG   = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // result actions
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_ADDED   = 3'd1;
    localparam logic [2:0] ACT_REFRESH = 3'd2;
    localparam logic [2:0] ACT_REMOVED = 3'd3;
    localparam logic [2:0] ACT_DROPPED = 3'd4;
    localparam logic [2:0] ACT_EXPIRED = 3'd5;
    localparam logic [2:0] ACT_CLEARED = 3'd6;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] sender_id;
        logic [7:0]  distance;
        logic        is_anchor;
        logic        is_preanchor;
        logic [31:0] now;
    } t_item;

    typedef struct packed {
        logic [2:0] action;
        logic [4:0] neighbor_count;
        logic [4:0] anchor_count;
        logic       was_present;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic       latch;
        logic       clear_tbl;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_en;
        logic       rd_next;
        logic       set_present;
        logic       anc_sub;
        logic       shift_wr;
        logic       cnt_dec;
        logic       append;
        logic       emit;
        logic [2:0] action;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       cnt_zero;
        logic       hit;
        logic       idx_last;
        logic       shift_more;
        logic       far;
        logic       full;
        logic       expired;
    } t_status;

endpackage

// ===== rtl/core/nbrtab_dp.sv =====
// ----------------------------------------------------------------------------
// nbrtab_dp
// entry memory, counters, walk index and result register
// ----------------------------------------------------------------------------
module nbrtab_dp #(
    parameter int DEPTH = nbrtab_pkg::TABLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nbrtab_pkg::t_item   i_item,
    input  logic [7:0]          i_min_distance,
    input  logic [31:0]         i_max_age,
    input  nbrtab_pkg::t_cmd    i_cmd,
    output nbrtab_pkg::t_status o_status,
    output logic                o_done,
    output nbrtab_pkg::t_result o_result
);
    import nbrtab_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] tstamp;
        logic [7:0]  distance;
        logic        anchor;
        logic        preanchor;
    } t_entry;

    t_entry        r_mem [DEPTH];
    t_entry        r_rdata;
    t_item         r_item;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_anchors;
    logic          r_present;
    logic          r_done;
    t_result       r_result;

    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    logic [CW-1:0] idx_plus1;
    logic [31:0]   age;

    assign rd_addr   = i_cmd.rd_next ? r_idx + IW'(1) : r_idx;
    assign idx_plus1 = CW'(r_idx) + CW'(1);
    assign age       = r_item.now - r_rdata.tstamp;

    always_comb begin
        wr_en   = i_cmd.shift_wr | i_cmd.append;
        wr_addr = i_cmd.append ? IW'(r_count) : r_idx;
        if (i_cmd.append) begin
            wr_data = '{id: r_item.sender_id, tstamp: r_item.now,
                        distance: r_item.distance, anchor: r_item.is_anchor,
                        preanchor: r_item.is_preanchor};
        end else begin
            wr_data = r_rdata;
        end
    end

    // entry store, one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_item;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.emit) begin
            r_result <= '{action: i_cmd.action, neighbor_count: 5'(r_count),
                          anchor_count: 5'(r_anchors), was_present: r_present};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_anchors <= '0;
            r_present <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
            if (i_cmd.latch) begin
                r_present <= 1'b0;
            end else if (i_cmd.set_present) begin
                r_present <= 1'b1;
            end
            priority if (i_cmd.clear_tbl) begin
                r_count   <= '0;
                r_anchors <= '0;
            end else if (i_cmd.append) begin
                r_count   <= r_count + CW'(1);
                r_anchors <= r_anchors + CW'(r_item.is_anchor);
            end else begin
                if (i_cmd.cnt_dec) begin
                    r_count <= r_count - CW'(1);
                end
                if (i_cmd.anc_sub) begin
                    r_anchors <= r_anchors - CW'(r_rdata.anchor);
                end
            end
        end
    end

    assign o_status = '{mode: r_item.mode,
                        cnt_zero: (r_count == '0),
                        hit: (r_rdata.id == r_item.sender_id),
                        idx_last: (idx_plus1 == r_count),
                        shift_more: (idx_plus1 < r_count),
                        far: (r_item.distance > i_min_distance),
                        full: (r_count == FULL_COUNT),
                        expired: (age > i_max_age)};

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== rtl/core/nbrtab_ctrl.sv =====
// ----------------------------------------------------------------------------
// nbrtab_ctrl
// sequencer for search, shift-down removal, append, expiry and clear
// ----------------------------------------------------------------------------
module nbrtab_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  nbrtab_pkg::t_status i_status,
    output nbrtab_pkg::t_cmd    o_cmd,
    output logic                o_busy
);
    import nbrtab_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_CMP    = 4'd2;
    localparam logic [3:0] ST_MISS   = 4'd3;
    localparam logic [3:0] ST_TCMP   = 4'd4;
    localparam logic [3:0] ST_SHCHK  = 4'd5;
    localparam logic [3:0] ST_SHWR   = 4'd6;
    localparam logic [3:0] ST_APPEND = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [2:0] r_action;
    logic [2:0] n_action;

    always_comb begin
        n_state  = r_state;
        n_action = r_action;
        o_cmd    = '0;
        o_cmd.action = r_action;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.latch   = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_action      = ACT_NONE;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_status.mode)
                    MODE_MSG: begin
                        if (i_status.cnt_zero) begin
                            n_state = ST_MISS;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = ST_CMP;
                        end
                    end
                    MODE_TICK: begin
                        if (i_status.cnt_zero) begin
                            n_state = ST_DONE;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = ST_TCMP;
                        end
                    end
                    MODE_CLEAR: begin
                        o_cmd.clear_tbl = 1'b1;
                        n_action        = ACT_CLEARED;
                        n_state         = ST_DONE;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_CMP: begin
                priority if (i_status.hit) begin
                    o_cmd.set_present = 1'b1;
                    o_cmd.anc_sub     = 1'b1;
                    n_action          = i_status.far ? ACT_REFRESH : ACT_REMOVED;
                    n_state           = ST_SHCHK;
                end else if (i_status.idx_last) begin
                    n_state = ST_MISS;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_MISS: begin
                priority if (!i_status.far) begin
                    n_state = ST_DONE;
                end else if (i_status.full) begin
                    n_action = ACT_DROPPED;
                    n_state  = ST_DONE;
                end else begin
                    n_action = ACT_ADDED;
                    n_state  = ST_APPEND;
                end
            end
            ST_TCMP: begin
                if (i_status.expired) begin
                    o_cmd.anc_sub = 1'b1;
                    n_action      = ACT_EXPIRED;
                    n_state       = ST_SHCHK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SHCHK: begin
                if (i_status.shift_more) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state       = ST_SHWR;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = (r_action == ACT_REFRESH) ? ST_APPEND : ST_DONE;
                end
            end
            ST_SHWR: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = ST_SHCHK;
            end
            ST_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = ST_DONE;
            end
            ST_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_action <= ACT_NONE;
        end else begin
            r_state  <= n_state;
            r_action <= n_action;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/core/neighbor_table_with_aging.sv =====
// ----------------------------------------------------------------------------
// neighbor_table_with_aging
// age-ordered neighbor table: message search, add, refresh and removal, tick expiry, clear
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the result is out. Each request gives exactly one result, shown on
// o_result for a single cycle with o_done high. The receiver cannot stall, so
// o_result must be captured in that cycle. Requests are handled one at a time
// and the entries live in a memory with one read and one write port, walked
// one entry per step, so latency depends on the table: a message searches from
// the head, a found entry is taken out by shifting each later entry down one
// slot, and a far one is appended again at the tail; a tick checks only the head.
// The user must make configuration writes only while busy is low; the block
// itself does not enforce it.
module neighbor_table_with_aging #(
    parameter int TABLE_DEPTH = nbrtab_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          start,
    output logic                          busy,
    input  nbrtab_pkg::t_item             i_item,
    // result channel
    output logic                          o_done,
    output nbrtab_pkg::t_result           o_result,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nbrtab_pkg::APB_AW-1:0] paddr,
    input  logic [nbrtab_pkg::APB_DW-1:0] pwdata,
    output logic [nbrtab_pkg::APB_DW-1:0] prdata,
    output logic                          pready
);
    import nbrtab_pkg::*;

    logic [7:0]  r_min_distance;
    logic [31:0] r_max_age;
    logic        cfg_wr;
    logic        reg_sel;
    t_cmd        cmd;
    t_status     status;
    logic        ctrl_busy;

    // register index is the word address
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_distance <= '0;
            r_max_age      <= MAX_AGE_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_MIN_DISTANCE: r_min_distance <= pwdata[7:0];
                REG_MAX_AGE:      r_max_age      <= pwdata[31:0];
                default:          r_max_age      <= r_max_age;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_sel)
            REG_MIN_DISTANCE: prdata = {24'd0, r_min_distance};
            REG_MAX_AGE:      prdata = r_max_age;
            default:          prdata = '0;
        endcase
    end

    // sequencer: search, shift-down, append, expiry, clear
    nbrtab_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (ctrl_busy)
    );

    // entry memory, counts and result register
    nbrtab_dp #(
        .DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_min_distance (r_min_distance),
        .i_max_age      (r_max_age),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_done         (o_done),
        .o_result       (o_result)
    );

    assign busy = ctrl_busy;

endmodule

// ===== tb/sv/tb_neighbor_table_with_aging.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_neighbor_table_with_aging
// self-checking bench for the age-ordered neighbor table
// ----------------------------------------------------------------------------
// A directed table covers empty-table ticks, the unused mode, add, refresh,
// close removal at head and tail, head expiry with and without time wrap, and
// clear. A fill burst then drives the table to full and past it. Random phases
// follow, each with its own min_distance and max_age written over the APB port
// and read back. Every request is run through a local model of the table at
// the edge where it is taken, and each o_done result is checked field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_neighbor_table_with_aging;

    import nbrtab_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    // mode code the block leaves unused
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct {
        t_item   req;
        bit      typed;
        t_result want;
    } t_dir_row;

    // dut ports; the inputs are all known from time zero
    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start   = 1'b0;
    logic                 busy;
    t_item                i_item  = '0;
    logic                 o_done;
    t_result              o_result;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [APB_AW-1:0]    paddr   = '0;
    logic [APB_DW-1:0]    pwdata  = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // local copy of the neighbor table
    logic [15:0] tbl_id   [DEPTH];
    logic [31:0] tbl_time [DEPTH];
    logic [7:0]  tbl_dist [DEPTH];
    logic        tbl_anc  [DEPTH];
    logic        tbl_pre  [DEPTH];
    int          tbl_count    = 0;
    int          tbl_anchors  = 0;
    logic [7:0]  cfg_min_dist = 8'd0;
    logic [31:0] cfg_max_age  = MAX_AGE_RESET;

    // predicted results, oldest first
    t_result  pending_results[$];
    t_dir_row dir_rows[$];

    int          err_count   = 0;
    int          result_seen = 0;
    bit          calm        = 1'b0;
    logic [31:0] clock_now   = 32'd0;
    logic [15:0] id_base     = 16'd0;
    int          id_pool     = 16;

    always #5 i_clk = ~i_clk;

    neighbor_table_with_aging #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------------
    // table model
    // ------------------------------------------------------------------------

    // take one entry out, later entries move down one slot
    function automatic void drop_entry(input int pos);
        tbl_anchors -= tbl_anc[pos];
        for (int k = pos; k + 1 < tbl_count; k++) begin
            tbl_id[k]   = tbl_id[k + 1];
            tbl_time[k] = tbl_time[k + 1];
            tbl_dist[k] = tbl_dist[k + 1];
            tbl_anc[k]  = tbl_anc[k + 1];
            tbl_pre[k]  = tbl_pre[k + 1];
        end
        tbl_count--;
    endfunction

    // append at the tail, refused when the table is full
    function automatic bit add_entry(input t_item req);
        if (tbl_count >= DEPTH) return 1'b0;
        tbl_id[tbl_count]   = req.sender_id;
        tbl_time[tbl_count] = req.now;
        tbl_dist[tbl_count] = req.distance;
        tbl_anc[tbl_count]  = req.is_anchor;
        tbl_pre[tbl_count]  = req.is_preanchor;
        tbl_anchors += req.is_anchor;
        tbl_count++;
        return 1'b1;
    endfunction

    function automatic t_result apply_request(input t_item req);
        t_result     res;
        int          pos;
        bit          far;
        logic [31:0] age;
        res = '0;
        case (req.mode)
            MODE_MSG: begin
                far = req.distance > cfg_min_dist;
                pos = -1;
                for (int k = 0; k < tbl_count; k++) begin
                    if (pos < 0 && tbl_id[k] == req.sender_id) pos = k;
                end
                if (pos >= 0) begin
                    // known id: always pulled out, re-appended only when far
                    res.was_present = 1'b1;
                    drop_entry(pos);
                    if (far) begin
                        void'(add_entry(req));
                        res.action = ACT_REFRESH;
                    end else begin
                        res.action = ACT_REMOVED;
                    end
                end else if (far) begin
                    res.action = add_entry(req) ? ACT_ADDED : ACT_DROPPED;
                end
            end
            MODE_TICK: begin
                // age with 32-bit wrap
                age = req.now - tbl_time[0];
                if (tbl_count > 0 && age > cfg_max_age) begin
                    drop_entry(0);
                    res.action = ACT_EXPIRED;
                end
            end
            MODE_CLEAR: begin
                tbl_count   = 0;
                tbl_anchors = 0;
                res.action  = ACT_CLEARED;
            end
            default: res.action = ACT_NONE;
        endcase
        res.neighbor_count = 5'(tbl_count);
        res.anchor_count   = 5'(tbl_anchors);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // result checker: o_done can not be held off, so every strobe is taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(o_result), 32'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_result.action !== want.action)
                    report_mismatch($sformatf("result %0d action", result_seen),
                                    32'(o_result.action), 32'(want.action));
                if (o_result.neighbor_count !== want.neighbor_count)
                    report_mismatch($sformatf("result %0d neighbor_count", result_seen),
                                    32'(o_result.neighbor_count), 32'(want.neighbor_count));
                if (o_result.anchor_count !== want.anchor_count)
                    report_mismatch($sformatf("result %0d anchor_count", result_seen),
                                    32'(o_result.anchor_count), 32'(want.anchor_count));
                if (o_result.was_present !== want.was_present)
                    report_mismatch($sformatf("result %0d was_present", result_seen),
                                    32'(o_result.was_present), 32'(want.was_present));
            end
            result_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // mostly short gaps, a few long ones, none at all in calm stretches
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // hold start until taken; the prediction is made at the accepting edge
    task automatic issue_request(input t_item req, input bit typed, input t_result want);
        t_result predicted;
        int      gap;
        start  <= 1'b1;
        i_item <= req;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        predicted = apply_request(req);
        pending_results.push_back(typed ? want : predicted);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and let every outstanding request finish
    task automatic drain_requests();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MIN_DISTANCE) cfg_min_dist = value[7:0];
        else cfg_max_age = value;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic idx, input logic [31:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want)
            report_mismatch($sformatf("register %0d readback", idx), got, want);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // random requests
    // ------------------------------------------------------------------------
    task automatic build_random(output t_item req);
        int r;
        req = t_item'({MODE_MSG, 16'($urandom), 8'($urandom), 1'($urandom),
                       1'($urandom), clock_now});
        clock_now += $urandom_range(0, 80);
        r = $urandom_range(0, 99);
        if (r < 60) begin
            // message from the working set of ids, sometimes close
            if ($urandom_range(0, 9) != 0)
                req.sender_id = id_base + 16'($urandom_range(0, id_pool - 1));
            if ($urandom_range(0, 3) == 0)
                req.distance = 8'($urandom_range(0, cfg_min_dist));
        end else if (r < 90) begin
            req.mode = MODE_TICK;
        end else if (r < 94) begin
            req.mode = MODE_CLEAR;
        end else if (r < 96) begin
            req.mode = MODE_SPARE;
        end else begin
            // stray message with all fields random
            req.now = $urandom;
        end
        if ($urandom_range(0, 29) == 0) req.now = $urandom;
    endtask

    task automatic run_phase(input logic [7:0] min_dist, input logic [31:0] max_age,
                             input logic [31:0] first_now, input int pool,
                             input int n_req);
        t_item req;
        drain_requests();
        write_reg(REG_MIN_DISTANCE, {24'd0, min_dist});
        write_reg(REG_MAX_AGE, max_age);
        check_reg(REG_MIN_DISTANCE, {24'd0, min_dist});
        check_reg(REG_MAX_AGE, max_age);
        clock_now = first_now;
        id_base   = ($urandom_range(0, 3) == 0) ? 16'hFFF8 : 16'($urandom);
        id_pool   = pool;
        for (int n = 0; n < n_req; n++) begin
            if (n % 30 == 0) calm = ($urandom_range(0, 3) == 0);
            // now and then wait for the pipe to empty before going on
            if ($urandom_range(0, 59) == 0) drain_requests();
            build_random(req);
            issue_request(req, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    task automatic add_row(input t_item req, input bit typed, input t_result want);
        t_dir_row row;
        row.req   = req;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    initial begin
        t_item req;

        // reset values: min_distance 0, max_age 1000
        add_row({MODE_TICK, 16'h0000, 8'h00, 1'b0, 1'b0, 32'd0}, 1'b1,
                {ACT_NONE, 5'd0, 5'd0, 1'b0});
        add_row({MODE_SPARE, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF}, 1'b1,
                {ACT_NONE, 5'd0, 5'd0, 1'b0});
        // new id at the threshold is refused
        add_row({MODE_MSG, 16'h0000, 8'h00, 1'b1, 1'b1, 32'd0}, 1'b1,
                {ACT_NONE, 5'd0, 5'd0, 1'b0});
        add_row({MODE_MSG, 16'hFFFF, 8'hFF, 1'b1, 1'b1, 32'hFFFF_FFFF}, 1'b1,
                {ACT_ADDED, 5'd1, 5'd1, 1'b0});
        add_row({MODE_MSG, 16'h0000, 8'h01, 1'b0, 1'b0, 32'd0}, 1'b1,
                {ACT_ADDED, 5'd2, 5'd1, 1'b0});
        // known far id moves to the tail and drops its anchor flag
        add_row({MODE_MSG, 16'hFFFF, 8'd200, 1'b0, 1'b1, 32'd5}, 1'b1,
                {ACT_REFRESH, 5'd2, 5'd0, 1'b1});
        // head aged exactly max_age stays, one tick more expires it
        add_row({MODE_TICK, 16'h1234, 8'h55, 1'b1, 1'b0, 32'd1000}, 1'b1,
                {ACT_NONE, 5'd2, 5'd0, 1'b0});
        add_row({MODE_TICK, 16'h0000, 8'h00, 1'b0, 1'b0, 32'd1001}, 1'b1,
                {ACT_EXPIRED, 5'd1, 5'd0, 1'b0});
        // now behind the entry time: the age wraps to a huge value
        add_row({MODE_TICK, 16'h0000, 8'h00, 1'b0, 1'b0, 32'd4}, 1'b1,
                {ACT_EXPIRED, 5'd0, 5'd0, 1'b0});
        add_row({MODE_MSG, 16'd7, 8'd10, 1'b1, 1'b0, 32'd100}, 1'b1,
                {ACT_ADDED, 5'd1, 5'd1, 1'b0});
        add_row({MODE_MSG, 16'd8, 8'd11, 1'b1, 1'b1, 32'd101}, 1'b0, '0);
        add_row({MODE_MSG, 16'd9, 8'd12, 1'b0, 1'b1, 32'd102}, 1'b0, '0);
        // known close ids: head then tail removed
        add_row({MODE_MSG, 16'd7, 8'd0, 1'b0, 1'b0, 32'd103}, 1'b1,
                {ACT_REMOVED, 5'd2, 5'd1, 1'b1});
        add_row({MODE_MSG, 16'd9, 8'd0, 1'b1, 1'b1, 32'd104}, 1'b1,
                {ACT_REMOVED, 5'd1, 5'd1, 1'b1});
        add_row({MODE_MSG, 16'd8, 8'd50, 1'b0, 1'b0, 32'd105}, 1'b1,
                {ACT_REFRESH, 5'd1, 5'd0, 1'b1});
        add_row({MODE_CLEAR, 16'hA5A5, 8'hAA, 1'b1, 1'b1, 32'h5A5A_5A5A}, 1'b1,
                {ACT_CLEARED, 5'd0, 5'd0, 1'b0});
        add_row({MODE_TICK, 16'h0000, 8'h00, 1'b0, 1'b0, 32'hFFFF_FFFF}, 1'b1,
                {ACT_NONE, 5'd0, 5'd0, 1'b0});

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) issue_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
        drain_requests();

        // fill to full with distinct far ids, the last one is dropped
        id_base = 16'($urandom);
        for (int n = 0; n <= DEPTH; n++) begin
            req = t_item'({MODE_MSG, id_base + 16'(n), 8'($urandom_range(1, 255)),
                           1'($urandom), 1'($urandom), clock_now});
            clock_now += $urandom_range(0, 20);
            issue_request(req, 1'b0, '0);
        end

        // threshold at the top: every message is close
        run_phase(8'd255, 32'd0, 32'd0, 20, 35);
        // zero age limit across the 32-bit wrap
        run_phase(8'd0, 32'd0, 32'hFFFF_FF00, 20, 70);
        // nothing ever expires, pool larger than the table
        run_phase(8'd40, 32'hFFFF_FFFF, 32'h8000_0000, 24, 70);
        run_phase(8'($urandom), $urandom_range(100, 2000), $urandom, 18, 90);
        run_phase(8'($urandom), $urandom, $urandom, 40, 60);
        // back to reset values
        run_phase(8'd0, MAX_AGE_RESET, 32'd0, 20, 90);

        drain_requests();
        // catch any stray strobe after the last result
        repeat (64) @(posedge i_clk);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // run limit, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
